FILE: rtl/tcm_pkg.sv
// Shared types and constants of the transport-stream continuity monitor.
`default_nettype none

package tcm_pkg;

   localparam int unsigned PID_W    = 13;
   localparam int unsigned PIDS     = 8192;
   localparam int unsigned MAX_SLOTS = 4;
   localparam int unsigned TOTAL_W  = 32;

   localparam logic [7:0] SYNC_VALUE    = 8'h47;
   localparam logic [4:0] PID_HI_MASK   = 5'h1f;

   typedef enum logic [2:0] {
      EV_IGNORED       = 3'd0,
      EV_SYNC_LOSS     = 3'd1,
      EV_DISCONTINUITY = 3'd2,
      EV_NO_PAYLOAD    = 3'd3,
      EV_FIRST         = 3'd4,
      EV_IN_ORDER      = 3'd5,
      EV_DUPLICATE     = 3'd6,
      EV_DROP          = 3'd7
   } ev_code_type;

   typedef struct packed {
      logic [1:0] stream_slot;
      logic [7:0] sync_byte;
      logic [7:0] header_byte1;
      logic [7:0] header_byte2;
      logic [7:0] header_byte3;
      logic [7:0] adapt_length;
      logic [7:0] adapt_flags;
   } req_beat_type;

   typedef struct packed {
      ev_code_type          event_res;
      logic [3:0]           lost_packets;
      logic [TOTAL_W-1:0]   packet_total;
      logic [TOTAL_W-1:0]   drop_total;
      logic [TOTAL_W-1:0]   duplicate_total;
      logic [TOTAL_W-1:0]   tei_total;
      logic [TOTAL_W-1:0]   discontinuity_total;
      logic [TOTAL_W-1:0]   sync_loss_total;
   } rsp_beat_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic read;
      logic update;
      logic clear_step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/tcm_if.sv
// Valid/ready channel interfaces for packet headers and results.
`default_nettype none

interface tcm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] stream_slot;
   logic [7:0] sync_byte;
   logic [7:0] header_byte1;
   logic [7:0] header_byte2;
   logic [7:0] header_byte3;
   logic [7:0] adapt_length;
   logic [7:0] adapt_flags;

   modport source (output valid, stream_slot, sync_byte, header_byte1, header_byte2,
                   header_byte3, adapt_length, adapt_flags, input ready);
   modport sink (input valid, stream_slot, sync_byte, header_byte1, header_byte2,
                 header_byte3, adapt_length, adapt_flags, output ready);
endinterface

interface tcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [3:0]  lost_packets;
   logic [31:0] packet_total;
   logic [31:0] drop_total;
   logic [31:0] duplicate_total;
   logic [31:0] tei_total;
   logic [31:0] discontinuity_total;
   logic [31:0] sync_loss_total;

   modport source (output valid, event_res, lost_packets, packet_total, drop_total,
                   duplicate_total, tei_total, discontinuity_total, sync_loss_total,
                   input ready);
   modport sink (input valid, event_res, lost_packets, packet_total, drop_total,
                 duplicate_total, tei_total, discontinuity_total, sync_loss_total,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/ts_continuity_monitor_unit.sv
// Top level of the transport-stream continuity monitor.
//
//   channel   dir  modport  beat
//   req_bus   in   sink     slot + first six header bytes of one TS packet
//   rsp_bus   out  source   event, lost count, per-PID and per-stream totals
//
// A header is taken only in the idle state: accept, table read
// (registered RAM output), then classify/update with write-back into the
// per-PID counter RAM; no new header is taken before that write-back.
// The result beat is valid once the update state has registered it.
// After reset a clearing pass zeroes the counter RAM, one entry a cycle,
// min(STREAMS, 4)*8192 entries (32768 at the default), with req_bus.ready low.
// A new header is taken while a result still waits; the next update then
// holds until rsp_bus takes the waiting beat.
`default_nettype none

module ts_continuity_monitor_unit import tcm_pkg::*; #(
   parameter int unsigned STREAMS      = 4,
   parameter int unsigned COUNTER_BITS = 32
) (
   input  wire      clock,
   input  wire      reset,
   tcm_req_if.sink  req_bus,
   tcm_rsp_if.source rsp_bus
);

   // only slots reachable through the 2-bit slot field get storage
   localparam int unsigned SLOTS   = (STREAMS < MAX_SLOTS) ? STREAMS : MAX_SLOTS;
   localparam int unsigned ENTRIES = SLOTS * PIDS;
   localparam int unsigned ADDR_W  = $clog2(ENTRIES);
   // entry: packets, drops, duplicates, TEI, discontinuities, {seen, last cc}
   localparam int unsigned ENTRY_W = 5 * COUNTER_BITS + 5;

   cmd_type            cmd;
   status_type         status;
   req_beat_type       req_beat;
   rsp_beat_type       rsp_beat;
   logic               req_ready;
   logic               rsp_valid;
   logic               ram_we, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   assign req_beat.stream_slot  = req_bus.stream_slot;
   assign req_beat.sync_byte    = req_bus.sync_byte;
   assign req_beat.header_byte1 = req_bus.header_byte1;
   assign req_beat.header_byte2 = req_bus.header_byte2;
   assign req_beat.header_byte3 = req_bus.header_byte3;
   assign req_beat.adapt_length = req_bus.adapt_length;
   assign req_beat.adapt_flags  = req_bus.adapt_flags;
   assign req_bus.ready         = req_ready;

   tcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   tcm_dpath #(
      .STREAMS      (STREAMS),
      .COUNTER_BITS (COUNTER_BITS),
      .SLOTS        (SLOTS),
      .ADDR_W       (ADDR_W),
      .ENTRY_W      (ENTRY_W)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_beat    (req_beat),
      .rsp_beat    (rsp_beat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_bus.ready),
      .ram_we      (ram_we),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tcm_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_bus.valid               = rsp_valid;
   assign rsp_bus.event_res           = rsp_beat.event_res;
   assign rsp_bus.lost_packets        = rsp_beat.lost_packets;
   assign rsp_bus.packet_total        = rsp_beat.packet_total;
   assign rsp_bus.drop_total          = rsp_beat.drop_total;
   assign rsp_bus.duplicate_total     = rsp_beat.duplicate_total;
   assign rsp_bus.tei_total           = rsp_beat.tei_total;
   assign rsp_bus.discontinuity_total = rsp_beat.discontinuity_total;
   assign rsp_bus.sync_loss_total     = rsp_beat.sync_loss_total;

endmodule

`default_nettype wire

FILE: rtl/tcm_ram.sv
// Single-write, single-read RAM with registered read data.
`default_nettype none

module tcm_ram #(
   parameter int unsigned DEPTH = 32768,
   parameter int unsigned WIDTH = 165
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/tcm_ctrl.sv
// Sequencer: clearing pass, accept, table read, update and write-back.
`default_nettype none

module tcm_ctrl import tcm_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // hold until the result register can take the beat
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

FILE: rtl/tcm_dpath.sv
// Header decode, classification, saturating counter update and result register.
`default_nettype none

module tcm_dpath import tcm_pkg::*; #(
   parameter int unsigned STREAMS      = 4,
   parameter int unsigned COUNTER_BITS = 32,
   parameter int unsigned SLOTS        = 4,
   parameter int unsigned ADDR_W       = 15,
   parameter int unsigned ENTRY_W      = 165
) (
   input  wire                 clock,
   input  wire                 reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  req_beat_type        req_beat,
   output rsp_beat_type        rsp_beat,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic                ram_we,
   output logic [ADDR_W-1:0]   ram_wr_addr,
   output logic [ENTRY_W-1:0]  ram_wr_data,
   output logic                ram_rd_en,
   output logic [ADDR_W-1:0]   ram_rd_addr,
   input  wire [ENTRY_W-1:0]   ram_rd_data
);

   localparam int unsigned CB      = COUNTER_BITS;
   localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned ENTRIES = SLOTS * PIDS;

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [3:0] b);
      logic [CB:0] s;
      s = {1'b0, a} + {{(CB-3){1'b0}}, b};
      return s[CB] ? {CB{1'b1}} : s[CB-1:0];
   endfunction

   // clamp a counter to the 32-bit report width
   function automatic logic [TOTAL_W-1:0] show(input logic [CB-1:0] v);
      logic [CB+TOTAL_W-1:0] ext;
      ext = {{TOTAL_W{1'b0}}, v};
      return (|ext[CB+TOTAL_W-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : ext[TOTAL_W-1:0];
   endfunction

   req_beat_type      in_ff;
   rsp_beat_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [CB-1:0]     sync_ff [SLOTS];

   logic [PID_W-1:0]  pid;
   logic [PID_W+1:0]  addr_full;
   logic [ADDR_W-1:0] addr;
   logic [SLOT_W-1:0] sidx;
   logic              slot_ok;
   logic [1:0]        afc;
   logic [3:0]        cc, last, expect_cc, lost;
   logic              tei, has_af, has_pl, disc, seen;
   logic [CB-1:0]     e_pkt, e_drop, e_dup, e_tei, e_disc;
   logic [CB-1:0]     n_pkt, n_drop, n_dup, n_tei, n_disc;
   logic [4:0]        e_lcs, n_lcs;
   logic [CB-1:0]     sync_cur, sync_new;
   logic              sync_we, entry_we;
   ev_code_type       ev;

   always_comb begin
      pid       = {in_ff.header_byte1[4:0] & PID_HI_MASK, in_ff.header_byte2};
      addr_full = {in_ff.stream_slot, pid};
      addr      = addr_full[ADDR_W-1:0];
      sidx      = in_ff.stream_slot[SLOT_W-1:0];
      slot_ok   = 32'(in_ff.stream_slot) < STREAMS;
      sync_cur  = sync_ff[sidx];
      sync_new  = sat_add(sync_cur, 4'd1);

      afc    = in_ff.header_byte3[5:4];
      cc     = in_ff.header_byte3[3:0];
      tei    = in_ff.header_byte1[7];
      has_af = afc[1];
      has_pl = afc[0];
      disc   = has_af && (in_ff.adapt_length != 8'd0) && in_ff.adapt_flags[7];

      {e_pkt, e_drop, e_dup, e_tei, e_disc, e_lcs} = ram_rd_data;
      last      = e_lcs[3:0];
      seen      = e_lcs[4];
      expect_cc = last + 4'd1;

      n_pkt    = e_pkt;
      n_drop   = e_drop;
      n_dup    = e_dup;
      n_tei    = e_tei;
      n_disc   = e_disc;
      n_lcs    = e_lcs;
      lost     = 4'd0;
      ev       = EV_IGNORED;
      sync_we  = 1'b0;
      entry_we = 1'b0;

      if (slot_ok && (in_ff.sync_byte == SYNC_VALUE) && (afc != 2'd0)) begin
         entry_we = 1'b1;
         n_pkt    = sat_add(e_pkt, 4'd1);
         if (tei) begin
            n_tei = sat_add(e_tei, 4'd1);
         end
         if (disc) begin
            n_disc = sat_add(e_disc, 4'd1);
            n_lcs  = {1'b0, last};
            ev     = EV_DISCONTINUITY;
         end else if (!has_pl) begin
            ev = EV_NO_PAYLOAD;
         end else if (!seen) begin
            n_lcs = {1'b1, cc};
            ev    = EV_FIRST;
         end else if (cc == expect_cc) begin
            n_lcs = {1'b1, cc};
            ev    = EV_IN_ORDER;
         end else if (cc == last) begin
            n_dup = sat_add(e_dup, 4'd1);
            ev    = EV_DUPLICATE;
         end else begin
            lost   = cc - expect_cc;
            n_drop = sat_add(e_drop, lost);
            n_lcs  = {1'b1, cc};
            ev     = EV_DROP;
         end
      end

      rsp_in = '0;
      if (slot_ok) begin
         if (in_ff.sync_byte != SYNC_VALUE) begin
            sync_we                = 1'b1;
            rsp_in.event_res       = EV_SYNC_LOSS;
            rsp_in.sync_loss_total = show(sync_new);
         end else begin
            rsp_in.event_res           = ev;
            rsp_in.lost_packets        = lost;
            rsp_in.packet_total        = show(n_pkt);
            rsp_in.drop_total          = show(n_drop);
            rsp_in.duplicate_total     = show(n_dup);
            rsp_in.tei_total           = show(n_tei);
            rsp_in.discontinuity_total = show(n_disc);
            rsp_in.sync_loss_total     = show(sync_cur);
         end
      end

      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign ram_rd_en   = cmd.read;
   assign ram_rd_addr = addr;
   assign ram_we      = cmd.clear_step | (cmd.update & entry_we);
   assign ram_wr_addr = cmd.clear_step ? clr_addr_ff : addr;
   assign ram_wr_data = cmd.clear_step ? '0 : {n_pkt, n_drop, n_dup, n_tei, n_disc, n_lcs};

   assign status.clear_last = (clr_addr_ff == ADDR_W'(ENTRIES - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            sync_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (cmd.update && sync_we) begin
            sync_ff[sidx] <= sync_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_beat;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_beat  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/tcm_checker.sv
// Port-level checks of the continuity monitor, bound to the top level.
`default_nettype none

module tcm_checker import tcm_pkg::*; (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  event_res,
   input wire [3:0]  lost_packets,
   input wire [31:0] packet_total,
   input wire [31:0] drop_total,
   input wire [31:0] duplicate_total,
   input wire [31:0] tei_total,
   input wire [31:0] discontinuity_total
);

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res)
         && $stable(packet_total))
      else $error("result beat changed while stalled");

   // clearing pass follows reset, so no header is taken right after it
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("header accepted during clearing pass");

   a_lost_only_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res != EV_DROP) |-> lost_packets == 4'd0)
      else $error("lost count outside a drop");

   a_sync_loss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res == EV_SYNC_LOSS) |-> packet_total == 32'd0
         && drop_total == 32'd0 && duplicate_total == 32'd0
         && tei_total == 32'd0 && discontinuity_total == 32'd0)
      else $error("per-PID totals on sync loss");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res != EV_IGNORED) && (event_res != EV_SYNC_LOSS)
         |-> packet_total != 32'd0)
      else $error("counted packet with zero packet total");

endmodule

bind ts_continuity_monitor_unit tcm_checker u_tcm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .event_res           (rsp_bus.event_res),
   .lost_packets        (rsp_bus.lost_packets),
   .packet_total        (rsp_bus.packet_total),
   .drop_total          (rsp_bus.drop_total),
   .duplicate_total     (rsp_bus.duplicate_total),
   .tei_total           (rsp_bus.tei_total),
   .discontinuity_total (rsp_bus.discontinuity_total)
);

`default_nettype wire
